// ----- sv/rbs_pkg.sv -----
package rbs_pkg;

	localparam int NUM_AXES  = 3;
	localparam int NUM_LANES = 2 * NUM_AXES;
	localparam int Q_BITS    = 32;

	localparam logic [31:0] T_MIN = 32'h8000_0000;
	localparam logic [31:0] T_MAX = 32'h7FFF_FFFF;

	typedef enum logic [2:0] {
		REG_BOX_MIN_X = 3'd0,
		REG_BOX_MIN_Y = 3'd1,
		REG_BOX_MIN_Z = 3'd2,
		REG_BOX_MAX_X = 3'd3,
		REG_BOX_MAX_Y = 3'd4,
		REG_BOX_MAX_Z = 3'd5
	} rbs_reg_t;

	// One slab plane in flight through the divider.
	typedef struct packed {
		logic [31:0] r;
		logic [31:0] nlo;
		logic [31:0] q;
		logic [31:0] d;
		logic        neg;
		logic        ovf;
	} rbs_lane_t;

	typedef struct packed {
		logic [NUM_AXES-1:0] dzero;
		logic [NUM_AXES-1:0] in_slab;
	} rbs_side_t;

	function automatic rbs_lane_t rbs_step(rbs_lane_t x);
		logic [32:0] rr;
		logic        ge;
		rbs_lane_t   y;
		rr     = {x.r, x.nlo[31]};
		ge     = rr >= {1'b0, x.d};
		y      = x;
		y.r    = ge ? 32'(rr - {1'b0, x.d}) : rr[31:0];
		y.nlo  = {x.nlo[30:0], 1'b0};
		y.q    = {x.q[30:0], ge};
		return y;
	endfunction

endpackage

// ----- sv/rbs_prep.sv -----
module rbs_prep #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [31:0] org [rbs_pkg::NUM_AXES],
	input  logic [31:0] dir [rbs_pkg::NUM_AXES],
	input  logic [31:0] bmin [rbs_pkg::NUM_AXES],
	input  logic [31:0] bmax [rbs_pkg::NUM_AXES],
	output logic out_valid,
	input  logic out_ready,
	output rbs_pkg::rbs_lane_t [rbs_pkg::NUM_LANES-1:0] lanes,
	output rbs_pkg::rbs_side_t side
);
	import rbs_pkg::*;

	localparam int NW = 33 + FRAC_BITS;

	rbs_lane_t [NUM_LANES-1:0] lane_c;
	rbs_side_t                 side_c;
	rbs_lane_t [NUM_LANES-1:0] lane_s1;
	rbs_side_t                 side_s1;
	logic                      vld_s1;

	always_comb begin
		logic [32:0]   diff;
		logic [32:0]   mag;
		logic [NW-1:0] num;
		logic [31:0]   bnd;
		for (int l = 0; l < NUM_LANES; l++) begin
			bnd  = (l % 2 == 0) ? bmin[l/2] : bmax[l/2];
			diff = {bnd[31], bnd} - {org[l/2][31], org[l/2]};
			mag  = diff[32] ? 33'(-diff) : diff;
			num  = {mag, {FRAC_BITS{1'b0}}};
			lane_c[l].r   = 32'(num[NW-1:32]);
			lane_c[l].nlo = num[31:0];
			lane_c[l].q   = '0;
			lane_c[l].d   = dir[l/2][31] ? 32'(-dir[l/2]) : dir[l/2];
			lane_c[l].neg = diff[32] ^ dir[l/2][31];
			lane_c[l].ovf = 1'b0;
		end
		for (int a = 0; a < NUM_AXES; a++) begin
			side_c.dzero[a]   = dir[a] == '0;
			side_c.in_slab[a] = ($signed(bmin[a]) <= $signed(org[a]))
				&& ($signed(org[a]) <= $signed(bmax[a]));
		end
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			lane_s1 <= lane_c;
			side_s1 <= side_c;
		end
	end

	assign out_valid = vld_s1;
	assign lanes     = lane_s1;
	assign side      = side_s1;

endmodule

// ----- sv/rbs_div.sv -----
module rbs_div (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rbs_pkg::rbs_lane_t [rbs_pkg::NUM_LANES-1:0] in_lanes,
	input  rbs_pkg::rbs_side_t in_side,
	output logic out_valid,
	input  logic out_ready,
	output rbs_pkg::rbs_lane_t [rbs_pkg::NUM_LANES-1:0] out_lanes,
	output rbs_pkg::rbs_side_t out_side
);
	import rbs_pkg::*;

	localparam int NS = Q_BITS + 1;

	rbs_lane_t [NUM_LANES-1:0] div_s [NS];
	rbs_side_t                 side_s [NS];
	logic      [NS-1:0]        vld_s;
	logic      [NS:0]          rdy;
	rbs_lane_t [NUM_LANES-1:0] in_c;

	always_comb begin
		rdy[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	always_comb begin
		in_c = in_lanes;
		for (int l = 0; l < NUM_LANES; l++) begin
			in_c[l].ovf = in_lanes[l].r >= in_lanes[l].d;
		end
	end

	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Stage 0 flags quotients of 2^32 or more; each later stage retires one bit.
	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			div_s[0]  <= in_c;
			side_s[0] <= in_side;
		end
		for (int k = 1; k < NS; k++) begin
			if (rdy[k] && vld_s[k-1]) begin
				for (int l = 0; l < NUM_LANES; l++) begin
					div_s[k][l] <= rbs_step(div_s[k-1][l]);
				end
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_lanes = div_s[NS-1];
	assign out_side  = side_s[NS-1];

endmodule

// ----- sv/rbs_reduce.sv -----
module rbs_reduce (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rbs_pkg::rbs_lane_t [rbs_pkg::NUM_LANES-1:0] in_lanes,
	input  rbs_pkg::rbs_side_t in_side,
	output logic out_valid,
	input  logic out_ready,
	output logic hit,
	output logic [31:0] t_near,
	output logic [31:0] t_far
);
	import rbs_pkg::*;

	localparam int NS = 4;

	logic [31:0]         t_s1 [NUM_LANES];
	rbs_side_t           side_s1;
	logic [31:0]         lo_s2 [NUM_AXES];
	logic [31:0]         up_s2 [NUM_AXES];
	logic                miss_s2;
	logic [31:0]         tn_s3;
	logic [31:0]         tf_s3;
	logic                miss_s3;
	logic                hit_s4;
	logic [31:0]         tn_s4;
	logic [31:0]         tf_s4;
	logic [NS-1:0]       vld_s;
	logic [NS:0]         rdy;

	logic [31:0]         t_c [NUM_LANES];
	logic [31:0]         lo_c [NUM_AXES];
	logic [31:0]         up_c [NUM_AXES];
	logic [NUM_AXES-1:0] miss_c;
	logic [31:0]         tn_c;
	logic [31:0]         tf_c;

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			if (in_lanes[l].neg) begin
				t_c[l] = (in_lanes[l].ovf || in_lanes[l].q[31]) ? T_MIN
					: 32'(-in_lanes[l].q);
			end else begin
				t_c[l] = (in_lanes[l].ovf || in_lanes[l].q[31]) ? T_MAX
					: in_lanes[l].q;
			end
		end
		for (int a = 0; a < NUM_AXES; a++) begin
			if (side_s1.dzero[a]) begin
				lo_c[a]   = T_MIN;
				up_c[a]   = T_MAX;
				miss_c[a] = !side_s1.in_slab[a];
			end else if ($signed(t_s1[2*a]) < $signed(t_s1[2*a+1])) begin
				lo_c[a]   = t_s1[2*a];
				up_c[a]   = t_s1[2*a+1];
				miss_c[a] = 1'b0;
			end else begin
				lo_c[a]   = t_s1[2*a+1];
				up_c[a]   = t_s1[2*a];
				miss_c[a] = 1'b0;
			end
		end
		tn_c = lo_s2[0];
		tf_c = up_s2[0];
		for (int a = 1; a < NUM_AXES; a++) begin
			if ($signed(lo_s2[a]) > $signed(tn_c)) tn_c = lo_s2[a];
			if ($signed(up_s2[a]) < $signed(tf_c)) tf_c = up_s2[a];
		end
	end

	always_comb begin
		rdy[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			t_s1    <= t_c;
			side_s1 <= in_side;
		end
		if (rdy[1] && vld_s[0]) begin
			lo_s2   <= lo_c;
			up_s2   <= up_c;
			miss_s2 <= |miss_c;
		end
		if (rdy[2] && vld_s[1]) begin
			tn_s3   <= tn_c;
			tf_s3   <= tf_c;
			miss_s3 <= miss_s2;
		end
		if (rdy[3] && vld_s[2]) begin
			hit_s4 <= !miss_s3 && ($signed(tf_s3) >= $signed(tn_s3));
			tn_s4  <= miss_s3 ? '0 : tn_s3;
			tf_s4  <= miss_s3 ? '0 : tf_s3;
		end
	end

	assign out_valid = vld_s[NS-1];
	assign hit       = hit_s4;
	assign t_near    = tn_s4;
	assign t_far     = tf_s4;

endmodule

// ----- sv/ray_box_slab_intersect.sv -----
// Tests one ray per transfer against the axis-aligned box held in six registers, using the
// slab method in signed fixed point with FRAC_BITS fraction bits. A new ray can be taken in
// every cycle unless the result side stalls; each ray passes one register stage of operand
// preparation, 33 stages of the one-bit-per-stage divider that runs the six slab planes side
// by side, and four stages of saturation, ordering, reduction and the hit test. A stall on the
// result side holds only the stages that are full. Box registers are written through the
// configuration channel, which is always ready, and should change only while no ray is in flight.
module ray_box_slab_intersect #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit, t_near, t_far, zero fill
	output logic [71:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import rbs_pkg::*;

	logic [31:0] bmin_q [NUM_AXES];
	logic [31:0] bmax_q [NUM_AXES];
	logic [31:0] org [NUM_AXES];
	logic [31:0] dir [NUM_AXES];

	logic                      pre_valid;
	logic                      pre_ready;
	rbs_lane_t [NUM_LANES-1:0] pre_lanes;
	rbs_side_t                 pre_side;
	logic                      div_valid;
	logic                      div_ready;
	rbs_lane_t [NUM_LANES-1:0] div_lanes;
	rbs_side_t                 div_side;
	logic                      hit;
	logic [31:0]               t_near;
	logic [31:0]               t_far;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				bmin_q[a] <= '0;
				bmax_q[a] <= 32'(1) << FRAC_BITS;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BOX_MIN_X: bmin_q[0] <= cfg_data;
				REG_BOX_MIN_Y: bmin_q[1] <= cfg_data;
				REG_BOX_MIN_Z: bmin_q[2] <= cfg_data;
				REG_BOX_MAX_X: bmax_q[0] <= cfg_data;
				REG_BOX_MAX_Y: bmax_q[1] <= cfg_data;
				REG_BOX_MAX_Z: bmax_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			org[a] = s_tdata[32*a +: 32];
			dir[a] = s_tdata[32*(a+NUM_AXES) +: 32];
		end
	end

	rbs_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.org       (org),
		.dir       (dir),
		.bmin      (bmin_q),
		.bmax      (bmax_q),
		.out_valid (pre_valid),
		.out_ready (pre_ready),
		.lanes     (pre_lanes),
		.side      (pre_side)
	);

	rbs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pre_valid),
		.in_ready  (pre_ready),
		.in_lanes  (pre_lanes),
		.in_side   (pre_side),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_lanes (div_lanes),
		.out_side  (div_side)
	);

	rbs_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_lanes  (div_lanes),
		.in_side   (div_side),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.hit       (hit),
		.t_near    (t_near),
		.t_far     (t_far)
	);

	assign m_tdata = {7'b0, t_far, t_near, hit};

	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input not ready while the result register is empty");

	a_hit_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && hit |-> $signed(t_far) >= $signed(t_near))
		else $error("hit reported with t_far below t_near");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !hit && (t_near == '0) |-> $signed(t_far) <= 0)
		else $error("miss with zero entry but positive exit");

endmodule
